// ===== rtl/handoff_frame_validator_core_assert.svh =====
// Assertion macros for the handoff frame validator core.
`ifndef HANDOFF_FRAME_VALIDATOR_CORE_ASSERT_SVH
`define HANDOFF_FRAME_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HFV_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HFV_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/hfv_pkg.sv =====
// Shared types, constants and schema tables for the handoff frame validator.
package hfv_pkg;

   // Field classes of a frame schema
   typedef enum logic [2:0] {
      FT_ID,
      FT_TEXT,
      FT_DIGEST,
      FT_ENV,
      FT_NUM8,
      FT_NUM1
   } field_kind_type;

   // Parse phase within one field
   typedef enum logic [1:0] {
      PH_START,
      PH_PREFIX,
      PH_CONTENT
   } phase_type;

   // Frame error codes as reported on the result channel
   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_TRUNCATED,
      ERR_OVER_LIMIT,
      ERR_TRAILING
   } error_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_ID_LIMIT       = 2'd0;
   localparam logic [1:0] CSR_TEXT_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_DIGEST_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_ENVELOPE_LIMIT = 2'd3;

   // Limit reset values
   localparam logic [31:0] ID_LIMIT_RESET       = 32'd600;
   localparam logic [31:0] TEXT_LIMIT_RESET     = 32'd2048;
   localparam logic [31:0] DIGEST_LIMIT_RESET   = 32'd128;
   localparam logic [31:0] ENVELOPE_LIMIT_RESET = 32'd16777216;

   // Frame kinds
   localparam logic [2:0] KIND_OFFER  = 3'd0;
   localparam logic [2:0] KIND_ACCEPT = 3'd1;
   localparam logic [2:0] KIND_REJECT = 3'd2;
   localparam logic [2:0] KIND_DATA   = 3'd3;
   localparam logic [2:0] KIND_ACK    = 3'd4;

   localparam logic [31:0] NUM8_BYTES = 32'd8;
   localparam logic [31:0] NUM1_BYTES = 32'd1;
   localparam int unsigned PREFIX_BYTES = 4;

   typedef struct packed {
      logic [31:0] id_limit;
      logic [31:0] text_limit;
      logic [31:0] digest_limit;
      logic [31:0] envelope_limit;
   } limits_type;

   // One result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] field_number;
      logic       is_length_byte;
      logic       is_value_byte;
      logic       frame_end;
      logic       frame_ok;
      error_type  error_code;
   } rsp_word_type;

   // Number of fields in each schema; unknown kinds have none
   function automatic logic [3:0] schema_count(input logic [2:0] kind);
      logic [3:0] n;
      unique case (kind)
         KIND_OFFER:  n = 4'd9;
         KIND_ACCEPT: n = 4'd4;
         KIND_REJECT: n = 4'd3;
         KIND_DATA:   n = 4'd2;
         KIND_ACK:    n = 4'd6;
         default:     n = 4'd0;
      endcase
      return n;
   endfunction

   // Field class at a given place of a schema
   function automatic field_kind_type schema_field(input logic [2:0] kind,
                                                   input logic [3:0] idx);
      field_kind_type f;
      f = FT_ID;
      unique case (kind)
         KIND_OFFER: begin
            unique case (idx)
               4'd1, 4'd2, 4'd3:       f = FT_TEXT;
               4'd4, 4'd6, 4'd7, 4'd8: f = FT_NUM8;
               4'd5:                   f = FT_DIGEST;
               default:                f = FT_ID;
            endcase
         end
         KIND_ACCEPT: begin
            unique case (idx)
               4'd1, 4'd2: f = FT_NUM8;
               4'd3:       f = FT_TEXT;
               default:    f = FT_ID;
            endcase
         end
         KIND_REJECT: begin
            unique case (idx)
               4'd1:    f = FT_NUM1;
               4'd2:    f = FT_NUM8;
               default: f = FT_ID;
            endcase
         end
         KIND_DATA: begin
            unique case (idx)
               4'd1:    f = FT_ENV;
               default: f = FT_ID;
            endcase
         end
         KIND_ACK: begin
            unique case (idx)
               4'd1:       f = FT_TEXT;
               4'd2, 4'd3: f = FT_NUM8;
               4'd4, 4'd5: f = FT_DIGEST;
               default:    f = FT_ID;
            endcase
         end
         default: f = FT_ID;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/handoff_frame_validator_core.sv =====
// Top level of the handoff frame validator: byte parser with registered result.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_stall    req_in_byte, req_frame_last, req_frame_kind
//   rsp_     out  rsp_valid/rsp_stall    byte, field label, frame_end, ok, error code
//   csr_     in   csr_valid/csr_ready    csr_index, csr_wdata
//
// One word per clock while req_stall is low: each byte is parsed in the cycle it
// is accepted and its result is captured in the result register.
// Reset (synchronous, active high) clears parse state and loads limit defaults.
// req_stall rises only while a result is held and rsp_stall is high.
// csr_ready is always high; limits take effect for the next accepted word.
module handoff_frame_validator_core
   import hfv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_last,
   input  logic [2:0]  req_frame_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_field_number,
   output logic        rsp_is_length_byte,
   output logic        rsp_is_value_byte,
   output logic        rsp_frame_end,
   output logic        rsp_frame_ok,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

`include "handoff_frame_validator_core_assert.svh"

   limits_type   limits;
   rsp_word_type word_in;
   rsp_word_type word_out;
   logic         req_fire;

   hfv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   hfv_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .in_byte    (req_in_byte),
      .frame_last (req_frame_last),
      .frame_kind (req_frame_kind),
      .limits     (limits),
      .word_in    (word_in)
   );

   hfv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_fire  (req_fire),
      .word_in   (word_in),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .word_out  (word_out)
   );

   assign rsp_out_byte       = word_out.out_byte;
   assign rsp_field_number   = word_out.field_number;
   assign rsp_is_length_byte = word_out.is_length_byte;
   assign rsp_is_value_byte  = word_out.is_value_byte;
   assign rsp_frame_end      = word_out.frame_end;
   assign rsp_frame_ok       = word_out.frame_ok;
   assign rsp_error_code     = word_out.error_code;

   // Checks on result labeling and flow
   `HFV_ASSERT_IMP(a_ok_clean, clock, reset, rsp_valid && rsp_frame_ok,
      rsp_frame_end && rsp_error_code == ERR_NONE, "frame_ok with error or mid-frame")
   `HFV_ASSERT_IMP(a_mid_quiet, clock, reset, rsp_valid && !rsp_frame_end,
      !rsp_frame_ok && rsp_error_code == ERR_NONE, "status reported before frame end")
   `HFV_ASSERT_IMP(a_one_label, clock, reset, rsp_valid,
      !(rsp_is_length_byte && rsp_is_value_byte), "byte labeled both length and value")
   `HFV_ASSERT_NEXT(a_fire_shows, clock, reset, req_valid && !req_stall,
      rsp_valid, "accepted word produced no result")

endmodule

// ===== rtl/hfv_csr.sv =====
// Length limit registers written through the configuration port.
module hfv_csr
   import hfv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output limits_type  limits
);

   limits_type limits_ff;
   limits_type limits_in;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ID_LIMIT:       limits_in.id_limit       = csr_wdata;
            CSR_TEXT_LIMIT:     limits_in.text_limit     = csr_wdata;
            CSR_DIGEST_LIMIT:   limits_in.digest_limit   = csr_wdata;
            CSR_ENVELOPE_LIMIT: limits_in.envelope_limit = csr_wdata;
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.id_limit       <= ID_LIMIT_RESET;
         limits_ff.text_limit     <= TEXT_LIMIT_RESET;
         limits_ff.digest_limit   <= DIGEST_LIMIT_RESET;
         limits_ff.envelope_limit <= ENVELOPE_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

// ===== rtl/hfv_parse.sv =====
// Frame parse state and per-byte labeling logic.
module hfv_parse
   import hfv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic [7:0]   in_byte,
   input  logic         frame_last,
   input  logic [2:0]   frame_kind,
   input  limits_type   limits,
   output rsp_word_type word_in
);

   logic [2:0]  kind_ff,  kind_in;
   logic [3:0]  idx_ff,   idx_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  pc_ff,    pc_in;
   logic [31:0] len_ff,   len_in;
   error_type   err_ff,   err_in;
   logic        mid_ff,   mid_in;

   logic [2:0]     kind_e;
   logic [3:0]     idx_e;
   phase_type      phase_e;
   logic [1:0]     pc_e;
   logic [31:0]    len_e;
   error_type      err_e;
   logic [3:0]     count;
   field_kind_type ftype;
   logic [31:0]    limit;
   phase_type      work_phase;
   logic [31:0]    work_len;
   logic [1:0]     work_pc;
   logic [31:0]    shifted;
   logic [31:0]    dec;

   // First byte of a frame starts from a clean state
   always_comb begin
      kind_e  = mid_ff ? kind_ff  : frame_kind;
      idx_e   = mid_ff ? idx_ff   : 4'd0;
      phase_e = mid_ff ? phase_ff : PH_START;
      pc_e    = mid_ff ? pc_ff    : 2'd0;
      len_e   = mid_ff ? len_ff   : 32'd0;
      err_e   = mid_ff ? err_ff   : ERR_NONE;
      count   = schema_count(kind_e);
      ftype   = schema_field(kind_e, idx_e);
   end

   // Limit for the current string field
   always_comb begin
      unique case (ftype)
         FT_ID:     limit = limits.id_limit;
         FT_TEXT:   limit = limits.text_limit;
         FT_DIGEST: limit = limits.digest_limit;
         default:   limit = limits.envelope_limit;
      endcase
   end

   // Field walk, length check and result labeling
   always_comb begin
      kind_in    = kind_e;
      idx_in     = idx_e;
      phase_in   = phase_e;
      pc_in      = pc_e;
      len_in     = len_e;
      err_in     = err_e;
      work_phase = phase_e;
      work_len   = len_e;
      work_pc    = pc_e;
      shifted    = 32'd0;
      dec        = 32'd0;
      word_in    = '0;
      word_in.out_byte   = in_byte;
      word_in.frame_end  = frame_last;
      word_in.error_code = ERR_NONE;

      if (err_e == ERR_NONE) begin
         if (idx_e >= count) begin
            err_in = ERR_TRAILING;
         end else begin
            word_in.field_number = idx_e;
            // field start: strings open a prefix, numbers go to content
            if (phase_e == PH_START) begin
               if (ftype == FT_ID || ftype == FT_TEXT || ftype == FT_DIGEST ||
                   ftype == FT_ENV) begin
                  work_phase = PH_PREFIX;
                  work_pc    = 2'd0;
                  work_len   = 32'd0;
               end else begin
                  work_phase = PH_CONTENT;
                  work_len   = (ftype == FT_NUM8) ? NUM8_BYTES : NUM1_BYTES;
               end
            end
            if (work_phase == PH_PREFIX) begin
               word_in.is_length_byte = 1'b1;
               shifted = {work_len[23:0], in_byte};
               if (work_pc == 2'(PREFIX_BYTES - 1)) begin
                  pc_in = 2'd0;
                  if (shifted > limit) begin
                     err_in   = ERR_OVER_LIMIT;
                     phase_in = PH_PREFIX;
                     len_in   = shifted;
                  end else if (shifted == 32'd0) begin
                     idx_in   = idx_e + 4'd1;
                     phase_in = PH_START;
                     len_in   = 32'd0;
                  end else begin
                     phase_in = PH_CONTENT;
                     len_in   = shifted;
                  end
               end else begin
                  pc_in    = work_pc + 2'd1;
                  phase_in = PH_PREFIX;
                  len_in   = shifted;
               end
            end else begin
               word_in.is_value_byte = 1'b1;
               dec = work_len - {31'd0, (work_len != 32'd0)};
               if (dec == 32'd0) begin
                  idx_in   = idx_e + 4'd1;
                  phase_in = PH_START;
                  pc_in    = 2'd0;
                  len_in   = 32'd0;
               end else begin
                  phase_in = work_phase;
                  pc_in    = work_pc;
                  len_in   = dec;
               end
            end
         end
      end

      // frame end: first error wins, else missing fields mean truncation
      mid_in = 1'b1;
      if (frame_last) begin
         mid_in = 1'b0;
         if (err_in != ERR_NONE) begin
            word_in.error_code = err_in;
         end else if (idx_in < count) begin
            word_in.error_code = ERR_TRUNCATED;
         end else begin
            word_in.frame_ok = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= 3'd0;
         idx_ff   <= 4'd0;
         phase_ff <= PH_START;
         pc_ff    <= 2'd0;
         len_ff   <= 32'd0;
         err_ff   <= ERR_NONE;
         mid_ff   <= 1'b0;
      end else if (req_fire) begin
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         len_ff   <= len_in;
         err_ff   <= err_in;
         mid_ff   <= mid_in;
      end
   end

endmodule

// ===== rtl/hfv_out.sv =====
// Result register with valid/stall handshake toward the consumer.
module hfv_out
   import hfv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         req_fire,
   input  rsp_word_type word_in,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type word_out
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // Hold off the producer only while a result sits unclaimed
   assign req_stall = valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign word_out  = word_ff;

endmodule
